### rtl/lim_pkg.sv
// Shared types, constants and the log2 helper of the stereo peak limiter.
// Used by lim_lane, lim_merge and the top level; depends on nothing.
`timescale 1ns / 1ps

package lim_pkg;

    localparam int SAMPLE_BITS_DEF       = 24;
    localparam int LOG_TABLE_ENTRIES_DEF = 1024;

    // config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KNEE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd3;

    localparam logic signed [15:0] THRESHOLD_RST = -16'sd256;
    localparam logic [12:0]        KNEE_RST      = 13'd0;
    localparam logic [23:0]        ATTACK_RST    = 24'd43865;
    localparam logic [23:0]        RELEASE_RST   = 24'd9148;

    // reduction in 1/65536 dB
    localparam int RED_W    = 25;
    localparam int REPORT_W = 17;
    localparam logic signed [RED_W-1:0] FLOOR_DB  = -25'sd9437184;
    localparam logic [23:0]             FLOOR_MAG = 24'd9437184;

    localparam logic [23:0] DECAY_Q24       = 24'd16760439;
    localparam logic [18:0] DB_PER_LOG2_Q16 = 19'd394566;
    localparam logic [29:0] LOG2_PER_DB_Q32 = 30'd713378626;

    typedef struct packed {
        logic signed [15:0] threshold;
        logic [12:0]        knee;
        logic [23:0]        atk_coef;
        logic [23:0]        rel_coef;
    } lim_cfg_t;

    // log2(x / 2^30) for x in [2^30, 2^31), 24 fraction bits, by repeated squaring
    function automatic logic [23:0] frac_log2(input logic [63:0] x_in);
        logic [63:0] x;
        logic [23:0] r;
        x = x_in;
        r = '0;
        for (int b = 23; b >= 0; b--) begin
            x = (x * x) >> 30;
            if (x >= 64'h8000_0000) begin
                x    = x >> 1;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

### rtl/lim_div.sv
// Restoring divider, one quotient bit per cycle, for the soft-knee curve.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module lim_div #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 22
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] num_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
                rem_reg <= '0;
                den_reg <= den;
                num_reg <= num;
            end else if (run_reg) begin
                rem_reg <= fits ? DEN_W'(shifted - {1'b0, den_reg}) : DEN_W'(shifted);
                num_reg <= {num_reg[NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

### rtl/lim_lane.sv
// One channel of the limiter: peak follower, dB level, knee, smoothing, gain.
// Depends on lim_pkg and lim_div; holds the log and exp tables as ROMs.
`timescale 1ns / 1ps

module lim_lane #(
    parameter int SAMPLE_BITS       = 24,
    parameter int LOG_TABLE_ENTRIES = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic                               take,
    input  logic [SAMPLE_BITS-1:0]             sample,
    input  lim_pkg::lim_cfg_t                  cfg,
    output logic                               done,
    output logic [SAMPLE_BITS-1:0]             out_sample,
    output logic signed [lim_pkg::RED_W-1:0]   reduction
);

    import lim_pkg::*;

    localparam int IW  = $clog2(LOG_TABLE_ENTRIES);
    localparam int SB  = SAMPLE_BITS;
    localparam int YW  = SAMPLE_BITS + 32;

    typedef logic [23:0] log_rom_t [LOG_TABLE_ENTRIES];
    typedef logic [31:0] exp_rom_t [LOG_TABLE_ENTRIES];

    function automatic log_rom_t build_log();
        log_rom_t t;
        for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
            t[i] = frac_log2(((64'(LOG_TABLE_ENTRIES) + 64'(i)) << 30) / LOG_TABLE_ENTRIES);
        end
        return t;
    endfunction

    function automatic exp_rom_t build_exp();
        exp_rom_t    t;
        logic [63:0] goal;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        t[0] = 32'h8000_0000;
        for (int i = 1; i < LOG_TABLE_ENTRIES; i++) begin
            goal = ((64'(LOG_TABLE_ENTRIES) - 64'(i)) << 24) / LOG_TABLE_ENTRIES;
            lo   = 64'h4000_0000;
            hi   = 64'h7FFF_FFFF;
            while (lo < hi) begin
                mid = lo + ((hi - lo + 64'd1) >> 1);
                if (64'(frac_log2(mid)) <= goal) lo = mid;
                else hi = mid - 64'd1;
            end
            t[i] = 32'(lo);
        end
        return t;
    endfunction

    localparam log_rom_t LOG_ROM = build_log();
    localparam exp_rom_t EXP_ROM = build_exp();

    typedef enum logic [3:0] {
        ST_IDLE, ST_PEAK, ST_LOG_ADDR, ST_LEVEL_MUL, ST_LEVEL, ST_KNEE, ST_KNEE_DIV,
        ST_SMOOTH_MUL, ST_SMOOTH, ST_GAIN_MUL, ST_EXP_READ, ST_OUT_MUL, ST_OUT, ST_DONE
    } lane_state_t;

    lane_state_t              state_reg;
    logic [31:0]              peak_reg;
    logic signed [RED_W-1:0]  red_reg;
    logic [SB-1:0]            smag_reg;
    logic                     neg_reg;
    logic [55:0]              decay_prod_reg;
    logic [4:0]               lead_reg;
    logic                     zero_reg;
    logic [23:0]              log_q_reg;
    logic [31:0]              exp_q_reg;
    logic [47:0]              lvl_prod_reg;
    logic                     lvl_pos_reg;
    logic signed [RED_W-1:0]  x_reg;
    logic signed [26:0]       tgt_reg;
    logic [47:0]              sm_prod_reg;
    logic                     up_reg;
    logic [53:0]              gain_prod_reg;
    logic [5:0]               k_reg;
    logic [YW-1:0]            y_prod_reg;
    logic [SB-1:0]            out_reg;

    // leading one and table addresses
    logic [4:0]       lead;
    logic [31:0]      frac_norm;
    logic [IW+30:0]   log_idx_prod;
    logic [IW-1:0]    log_addr;
    logic [IW+23:0]   exp_idx_prod;
    logic [IW-1:0]    exp_addr;

    always_comb begin
        lead = '0;
        for (int b = 0; b < 32; b++) begin
            if (peak_reg[b]) lead = 5'(b);
        end
    end

    assign frac_norm    = peak_reg << (5'd31 - lead);
    assign log_idx_prod = (IW+31)'(frac_norm[30:0]) * (IW+31)'(LOG_TABLE_ENTRIES);
    assign log_addr     = log_idx_prod[IW+30:31];
    assign exp_idx_prod = (IW+24)'(gain_prod_reg[47:24]) * (IW+24)'(LOG_TABLE_ENTRIES);
    assign exp_addr     = exp_idx_prod[IW+23:24];

    always_ff @(posedge aclk) begin
        log_q_reg <= LOG_ROM[log_addr];
        exp_q_reg <= EXP_ROM[exp_addr];
    end

    // level in log2 units, 24 fraction bits
    logic signed [33:0] lvl;
    logic [28:0]        lvl_mag;
    assign lvl     = $signed(((34'(lead_reg) - 34'(SB - 1)) << 24) + 34'(log_q_reg));
    assign lvl_mag = 29'(-lvl);

    // knee, all in 1/65536 dB
    logic signed [26:0] thr_q;
    logic signed [26:0] half_q;
    logic signed [26:0] xq;
    logic signed [26:0] knee_d;
    logic [41:0]        knee_sq;
    logic [21:0]        knee_den;
    logic               div_start;
    logic               div_done;
    logic [41:0]        div_quot;

    assign thr_q    = $signed({{3{cfg.threshold[15]}}, cfg.threshold, 8'h00});
    assign half_q   = $signed({7'b0, cfg.knee, 7'b0});
    assign xq       = 27'(x_reg);
    assign knee_d   = xq - thr_q + half_q;
    assign knee_sq  = 42'(knee_d[20:0]) * 42'(knee_d[20:0]);
    assign knee_den = {cfg.knee, 9'b0};

    logic knee_hard;
    logic knee_below;
    logic knee_above;
    assign knee_hard  = cfg.knee == '0;
    assign knee_below = xq < thr_q - half_q;
    assign knee_above = xq > thr_q + half_q;
    assign div_start  = state_reg == ST_KNEE && !knee_hard && !knee_below && !knee_above;

    lim_div #(.NUM_W(42), .DEN_W(22)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (knee_sq),
        .den     (knee_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // smoothing toward the clamped target gain
    logic signed [26:0]      g_raw;
    logic signed [RED_W-1:0] g_cl;
    logic signed [25:0]      diff;
    logic [23:0]             diff_mag;
    logic [23:0]             step;
    logic signed [25:0]      r_new;
    logic [47:0]             step_sum;

    assign g_raw    = tgt_reg - xq;
    assign g_cl     = (g_raw > 27'sd0) ? '0 :
                      (g_raw < 27'(FLOOR_DB)) ? FLOOR_DB : RED_W'(g_raw);
    assign diff     = 26'(g_cl) - 26'(red_reg);
    assign diff_mag = diff[25] ? 24'(-diff) : 24'(diff);
    assign step_sum = sm_prod_reg + 48'h80_0000;
    assign step     = step_sum[47:24];
    assign r_new    = up_reg ? 26'(red_reg) + 26'(step) : 26'(red_reg) - 26'(step);

    logic [YW-1:0] y_shift;
    logic [SB-1:0] y_mag;
    assign y_shift = y_prod_reg >> (7'd31 + 7'(k_reg));
    assign y_mag   = (k_reg >= 6'd32) ? '0 : SB'(y_shift);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            peak_reg  <= '0;
            red_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        neg_reg        <= sample[SB-1];
                        smag_reg       <= sample[SB-1] ? SB'(-sample) : sample;
                        decay_prod_reg <= 56'(peak_reg) * 56'(DECAY_Q24);
                        state_reg      <= ST_PEAK;
                    end
                end
                ST_PEAK: begin
                    peak_reg  <= (32'(smag_reg) > decay_prod_reg[55:24]) ?
                                 32'(smag_reg) : decay_prod_reg[55:24];
                    state_reg <= ST_LOG_ADDR;
                end
                ST_LOG_ADDR: begin
                    lead_reg  <= lead;
                    zero_reg  <= peak_reg == '0;
                    state_reg <= ST_LEVEL_MUL;
                end
                ST_LEVEL_MUL: begin
                    lvl_pos_reg  <= lvl >= 34'sd0;
                    lvl_prod_reg <= 48'(lvl_mag) * 48'(DB_PER_LOG2_Q16);
                    state_reg    <= ST_LEVEL;
                end
                ST_LEVEL: begin
                    if (zero_reg) x_reg <= FLOOR_DB;
                    else if (lvl_pos_reg) x_reg <= '0;
                    else if (lvl_prod_reg[47:24] > FLOOR_MAG) x_reg <= FLOOR_DB;
                    else x_reg <= RED_W'(-$signed({1'b0, lvl_prod_reg[47:24]}));
                    state_reg <= ST_KNEE;
                end
                ST_KNEE: begin
                    if (knee_hard) begin
                        tgt_reg   <= (xq > thr_q) ? thr_q : xq;
                        state_reg <= ST_SMOOTH_MUL;
                    end else if (knee_below) begin
                        tgt_reg   <= xq;
                        state_reg <= ST_SMOOTH_MUL;
                    end else if (knee_above) begin
                        tgt_reg   <= thr_q;
                        state_reg <= ST_SMOOTH_MUL;
                    end else begin
                        state_reg <= ST_KNEE_DIV;
                    end
                end
                ST_KNEE_DIV: begin
                    if (div_done) begin
                        tgt_reg   <= xq - $signed(27'(div_quot));
                        state_reg <= ST_SMOOTH_MUL;
                    end
                end
                ST_SMOOTH_MUL: begin
                    up_reg      <= diff > 26'sd0;
                    sm_prod_reg <= 48'(diff_mag) *
                                   48'((diff > 26'sd0) ? cfg.rel_coef : cfg.atk_coef);
                    state_reg   <= ST_SMOOTH;
                end
                ST_SMOOTH: begin
                    if (r_new > 26'sd0) red_reg <= '0;
                    else if (r_new < 26'(FLOOR_DB)) red_reg <= FLOOR_DB;
                    else red_reg <= RED_W'(r_new);
                    state_reg <= ST_GAIN_MUL;
                end
                ST_GAIN_MUL: begin
                    gain_prod_reg <= 54'($unsigned(24'(-red_reg))) * 54'(LOG2_PER_DB_Q32);
                    state_reg     <= ST_EXP_READ;
                end
                ST_EXP_READ: begin
                    k_reg     <= gain_prod_reg[53:48];
                    state_reg <= ST_OUT_MUL;
                end
                ST_OUT_MUL: begin
                    y_prod_reg <= YW'(smag_reg) * YW'(exp_q_reg);
                    state_reg  <= ST_OUT;
                end
                ST_OUT: begin
                    out_reg   <= neg_reg ? SB'(-y_mag) : y_mag;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (take) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign done       = state_reg == ST_DONE;
    assign out_sample = out_reg;
    assign reduction  = red_reg;

endmodule

### rtl/lim_merge.sv
// Merging stage: joins both lanes, picks the deeper reduction, holds the output word.
// Depends on lim_pkg.
`timescale 1ns / 1ps

module lim_merge #(
    parameter int SAMPLE_BITS = 24,
    parameter int OUT_W       = 72
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [1:0]                       lanes_done,
    input  logic [SAMPLE_BITS-1:0]           left_in,
    input  logic [SAMPLE_BITS-1:0]           right_in,
    input  logic signed [lim_pkg::RED_W-1:0] red_left,
    input  logic signed [lim_pkg::RED_W-1:0] red_right,
    input  logic                             m_tready,
    output logic                             take,
    output logic                             m_tvalid,
    output logic [OUT_W-1:0]                 m_tdata
);

    import lim_pkg::*;

    localparam int SB = SAMPLE_BITS;

    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        m_tdata_reg;
    logic signed [RED_W-1:0] red_min;
    logic [23:0]             red_mag;
    logic [REPORT_W-1:0]     report;
    logic [OUT_W-1:0]        word_next;

    assign take    = (&lanes_done) && (!m_tvalid_reg || m_tready);
    assign red_min = (red_left < red_right) ? red_left : red_right;
    assign red_mag = 24'(-red_min);
    assign report  = REPORT_W'(-$signed({1'b0, red_mag[23:8]}));

    always_comb begin
        word_next                     = '0;
        word_next[SB-1:0]             = left_in;
        word_next[2*SB-1:SB]          = right_in;
        word_next[2*SB+REPORT_W-1:2*SB] = report;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (take) begin
            m_tvalid_reg <= 1'b1;
            m_tdata_reg  <= word_next;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### rtl/stereo_soft_knee_peak_limiter_unit.sv
// Top level of the stereo soft-knee peak limiter: config registers, two lanes, merge.
// Depends on lim_pkg, lim_lane, lim_div and lim_merge.
`timescale 1ns / 1ps

// Usage:
//   s_ channel takes one stereo word (left and right sample). m_ channel returns
//   one word per input: both limited samples and the deeper gain reduction.
//   cfg_ channel writes threshold (0), knee (1), attack (2), release (3); it is
//   always ready and must only be used while no word is in flight.
// Path: a hard knee or a level outside the knee skips the divider; inside the knee a
//   42-step serial divider forms the knee curve. Each lane is a multi-cycle
//   sequencer, so one word is processed at a time.
// Both channels are computed by identical lanes side by side; the merge stage
//   keeps the result in an output register, so the next input word is taken as
//   soon as the lanes hand over, even while the receiver still stalls.
// Reset: aresetn (synchronous, active low) clears peak levels, reductions to 0 dB
//   and restores the config defaults; no word is pending afterwards.
// A stalled receiver holds m_tdata stable; a finished lane pair waits until the
//   output register is free.

module stereo_soft_knee_peak_limiter_unit #(
    parameter int SAMPLE_BITS       = lim_pkg::SAMPLE_BITS_DEF,
    parameter int LOG_TABLE_ENTRIES = lim_pkg::LOG_TABLE_ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // left_sample, right_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // left_out, right_out, reduction_now
    output logic [((2*SAMPLE_BITS+lim_pkg::REPORT_W+7)/8)*8-1:0] m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lim_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lim_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import lim_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int OUT_W = ((2*SAMPLE_BITS+REPORT_W+7)/8)*8;

    lim_cfg_t cfg_reg;
    logic     busy_reg;
    logic     in_accept;
    logic     take;

    logic [1:0]              lane_done;
    logic [SB-1:0]           lane_in   [2];
    logic [SB-1:0]           lane_out  [2];
    logic signed [RED_W-1:0] lane_red  [2];

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign in_accept = s_tvalid && s_tready;
    assign lane_in[0] = s_tdata[SB-1:0];
    assign lane_in[1] = s_tdata[2*SB-1:SB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold <= THRESHOLD_RST;
            cfg_reg.knee      <= KNEE_RST;
            cfg_reg.atk_coef  <= ATTACK_RST;
            cfg_reg.rel_coef  <= RELEASE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_THRESHOLD: cfg_reg.threshold <= $signed(cfg_data[15:0]);
                CFG_KNEE:      cfg_reg.knee      <= cfg_data[12:0];
                CFG_ATTACK:    cfg_reg.atk_coef  <= cfg_data[23:0];
                CFG_RELEASE:   cfg_reg.rel_coef  <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) busy_reg <= 1'b0;
        else if (in_accept) busy_reg <= 1'b1;
        else if (take) busy_reg <= 1'b0;
    end

    for (genvar ln = 0; ln < 2; ln++) begin : g_lane
        lim_lane #(
            .SAMPLE_BITS       (SAMPLE_BITS),
            .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES)
        ) u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .start      (in_accept),
            .take       (take),
            .sample     (lane_in[ln]),
            .cfg        (cfg_reg),
            .done       (lane_done[ln]),
            .out_sample (lane_out[ln]),
            .reduction  (lane_red[ln])
        );
    end

    lim_merge #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .OUT_W       (OUT_W)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .lanes_done (lane_done),
        .left_in    (lane_out[0]),
        .right_in   (lane_out[1]),
        .red_left   (lane_red[0]),
        .red_right  (lane_red[1]),
        .m_tready   (m_tready),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

    a_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> busy_reg)
        else $error("lanes handed over with no word in flight");

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |-> (lane_done == 2'b00))
        else $error("input accepted while a lane still holds a result");

    a_rise_from_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(take))
        else $error("output word appeared without a lane handover");

    a_reduction_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2*SB+REPORT_W-1] || m_tdata[2*SB+REPORT_W-1:2*SB] == '0))
        else $error("reported reduction is positive");

endmodule
